// ===== rtl/fcm_pkg.sv =====
// ----------------------------------------------------------------------------
// fcm_pkg
// Shared types and constants for the allocation table chain manager.
// ----------------------------------------------------------------------------
`default_nettype none

package fcm_pkg;

    localparam int DEF_TABLE_ENTRIES = 8192;

    localparam logic [15:0] END_MARK = 16'hFFFF;

    // Configuration register indexes
    localparam logic [1:0] CFG_BLOCK_COUNT = 2'd0;
    localparam logic [1:0] CFG_DATA_START  = 2'd1;
    localparam logic [13:0] CFG_BLOCK_COUNT_RST = 14'd8192;
    localparam logic [15:0] CFG_DATA_START_RST  = 16'd0;

    // Command modes
    localparam logic [2:0] MODE_LOAD  = 3'd0;
    localparam logic [2:0] MODE_READ  = 3'd1;
    localparam logic [2:0] MODE_ALLOC = 3'd2;
    localparam logic [2:0] MODE_FREE  = 3'd3;
    localparam logic [2:0] MODE_WALK  = 3'd4;
    localparam logic [2:0] MODE_COUNT = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_PAST    = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_LOAD,
        OP_SCAN_INIT,
        OP_SCAN,
        OP_LINK,
        OP_MARK,
        OP_MARK_ADV,
        OP_HEAD_NEW,
        OP_FREE,
        OP_ADV,
        OP_DONE
    } t_op;

    // Result block selection
    typedef enum logic [2:0] {
        BS_ZERO,
        BS_CUR,
        BS_HEAD,
        BS_RDATA,
        BS_FREE
    } t_bsel;

    typedef struct packed {
        t_op        op;
        logic [1:0] st;
        t_bsel      bsel;
        logic       cnt_out;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] mode;
        logic       extend;
        logic       cur_in_range;
        logic       cur_is_end;
        logic       rd_zero;
        logic       rd_end;
        logic       steps_zero;
        logic       scan_found;
        logic       scan_done;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/fcm_datapath.sv =====
// ----------------------------------------------------------------------------
// fcm_datapath
// Link table memory, configuration registers, walk and scan registers.
// ----------------------------------------------------------------------------
`default_nettype none

module fcm_datapath
    import fcm_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [2:0]  i_mode,
    input  wire logic [15:0] i_block,
    input  wire logic [15:0] i_entry_value,
    input  wire logic [12:0] i_steps,
    input  wire logic        i_extend,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_stat         o_stat,
    output logic             o_done,
    output logic [15:0]      o_block_out,
    output logic [15:0]      o_disk_block,
    output logic             o_head_allocated,
    output logic [12:0]      o_free_count,
    output logic [1:0]       o_status
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [16:0] TE = 17'(TABLE_ENTRIES);

    logic [15:0] mem [TABLE_ENTRIES];

    logic [13:0] r_count;
    logic [15:0] r_start;
    logic [2:0]  r_mode;
    logic [15:0] r_val;
    logic [12:0] r_steps;
    logic        r_extend;
    logic [15:0] r_cur;
    logic [15:0] r_head;
    logic [15:0] r_free;
    logic        r_headnew;
    logic [12:0] r_cnt;
    logic [16:0] r_scan_addr;
    logic        r_pend;
    logic [15:0] r_pend_addr;
    logic [15:0] r_rdata;

    logic [16:0] n_wide;
    logic [15:0] n_used;
    logic        scan_more;
    logic        found;
    logic        wr_en;
    logic [15:0] wr_addr;
    logic [15:0] wr_data;
    logic [15:0] rd_addr;
    logic [15:0] bout;

    // Entries in use, capped at the table depth
    assign n_wide = ({3'b000, r_count} > TE) ? TE : {3'b000, r_count};
    assign n_used = n_wide[15:0];

    assign scan_more = (r_scan_addr < {1'b0, n_used});
    assign found     = r_pend && (r_rdata == 16'd0);

    always_comb begin
        o_stat.mode         = r_mode;
        o_stat.extend       = r_extend;
        o_stat.cur_in_range = (r_cur < n_used);
        o_stat.cur_is_end   = (r_cur == END_MARK);
        o_stat.rd_zero      = (r_rdata == 16'd0);
        o_stat.rd_end       = (r_rdata == END_MARK);
        o_stat.steps_zero   = (r_steps == 13'd0);
        o_stat.scan_found   = found;
        o_stat.scan_done    = !r_pend && !scan_more;
    end

    // Table write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_cur;
        wr_data = 16'd0;
        case (i_cmd.op)
            OP_LOAD: begin
                wr_en   = 1'b1;
                wr_data = r_val;
            end
            OP_LINK: begin
                wr_en   = 1'b1;
                wr_data = r_free;
            end
            OP_MARK, OP_MARK_ADV, OP_HEAD_NEW: begin
                wr_en   = 1'b1;
                wr_addr = r_free;
                wr_data = END_MARK;
            end
            OP_FREE: begin
                wr_en   = 1'b1;
            end
            default: begin
                wr_en   = 1'b0;
            end
        endcase
    end

    assign rd_addr = (i_cmd.op == OP_SCAN) ? r_scan_addr[15:0] : r_cur;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr[AW-1:0]] <= wr_data;
        end
        r_rdata <= mem[rd_addr[AW-1:0]];
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CFG_BLOCK_COUNT_RST;
            r_start <= CFG_DATA_START_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BLOCK_COUNT: r_count <= i_cfg_data[13:0];
                CFG_DATA_START:  r_start <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Walk, scan and command registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LATCH: begin
                r_mode    <= i_mode;
                r_val     <= i_entry_value;
                r_steps   <= i_steps;
                r_extend  <= i_extend;
                r_cur     <= i_block;
                r_head    <= i_block;
                r_headnew <= 1'b0;
                r_cnt     <= 13'd0;
            end
            OP_SCAN_INIT: begin
                r_scan_addr <= 17'd1;
                r_pend      <= 1'b0;
                r_cnt       <= 13'd0;
            end
            OP_SCAN: begin
                if (scan_more) begin
                    r_pend      <= 1'b1;
                    r_pend_addr <= r_scan_addr[15:0];
                    r_scan_addr <= r_scan_addr + 17'd1;
                end else begin
                    r_pend <= 1'b0;
                end
                if (found) begin
                    r_free <= r_pend_addr;
                    r_cnt  <= r_cnt + 13'd1;
                end
            end
            OP_MARK_ADV: begin
                r_cur   <= r_free;
                r_steps <= r_steps - 13'd1;
            end
            OP_HEAD_NEW: begin
                r_cur     <= r_free;
                r_head    <= r_free;
                r_headnew <= 1'b1;
            end
            OP_FREE: begin
                r_cur <= r_rdata;
            end
            OP_ADV: begin
                r_cur   <= r_rdata;
                r_steps <= r_steps - 13'd1;
            end
            default: begin
            end
        endcase
    end

    // Result selection
    always_comb begin
        case (i_cmd.bsel)
            BS_CUR:   bout = r_cur;
            BS_HEAD:  bout = r_head;
            BS_RDATA: bout = r_rdata;
            BS_FREE:  bout = r_free;
            default:  bout = 16'd0;
        endcase
    end

    // Result register and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= (i_cmd.op == OP_DONE);
        end
        if (i_cmd.op == OP_DONE) begin
            o_block_out      <= bout;
            o_disk_block     <= bout + r_start;
            o_head_allocated <= r_headnew;
            o_free_count     <= i_cmd.cnt_out ? r_cnt : 13'd0;
            o_status         <= i_cmd.st;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fcm_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcm_ctrl
// Command sequencer: drives the datapath through load, read, allocate, free,
// walk and count sequences.
// ----------------------------------------------------------------------------
`default_nettype none

module fcm_ctrl
    import fcm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_ALINK,
        S_AMARK,
        S_FREE,
        S_FCHK,
        S_WHEAD,
        S_WCHK,
        S_WRD,
        S_WEXT,
        S_WEXT2,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        RET_ALLOC,
        RET_WHEAD,
        RET_WEXT,
        RET_COUNT
    } t_ret;

    t_state     r_state, n_state;
    t_ret       r_ret, n_ret;
    logic [1:0] r_st, n_st;
    t_bsel      r_bsel, n_bsel;
    logic       r_cnt_out, n_cnt_out;
    t_op        op;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        o_cmd.op      = op;
        o_cmd.st      = r_st;
        o_cmd.bsel    = r_bsel;
        o_cmd.cnt_out = r_cnt_out;
    end

    // Next state and operation
    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_st      = r_st;
        n_bsel    = r_bsel;
        n_cnt_out = r_cnt_out;
        op        = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    op        = OP_LATCH;
                    n_state   = S_DISPATCH;
                    n_st      = ST_OK;
                    n_bsel    = BS_ZERO;
                    n_cnt_out = 1'b0;
                end
            end
            S_DISPATCH: begin
                n_state = S_DONE;
                case (i_stat.mode)
                    MODE_LOAD: begin
                        if (i_stat.cur_in_range) begin
                            op     = OP_LOAD;
                            n_bsel = BS_CUR;
                        end else begin
                            n_st = ST_RANGE;
                        end
                    end
                    MODE_READ: begin
                        if (i_stat.cur_in_range) begin
                            n_bsel = BS_RDATA;
                        end else begin
                            n_st = ST_RANGE;
                        end
                    end
                    MODE_ALLOC: begin
                        if (!i_stat.cur_is_end && !i_stat.cur_in_range) begin
                            n_st = ST_RANGE;
                        end else begin
                            op      = OP_SCAN_INIT;
                            n_ret   = RET_ALLOC;
                            n_state = S_SCAN;
                        end
                    end
                    MODE_FREE: begin
                        if (i_stat.cur_is_end) begin
                            n_st = ST_OK;
                        end else if (!i_stat.cur_in_range) begin
                            n_st = ST_RANGE;
                        end else begin
                            n_state = S_FREE;
                        end
                    end
                    MODE_WALK: begin
                        if (!i_stat.cur_is_end) begin
                            n_state = S_WCHK;
                        end else if (!i_stat.extend) begin
                            n_st   = ST_PAST;
                            n_bsel = BS_HEAD;
                        end else begin
                            op      = OP_SCAN_INIT;
                            n_ret   = RET_WHEAD;
                            n_state = S_SCAN;
                        end
                    end
                    MODE_COUNT: begin
                        op      = OP_SCAN_INIT;
                        n_ret   = RET_COUNT;
                        n_state = S_SCAN;
                    end
                    default: begin
                        n_st = ST_OK;
                    end
                endcase
            end
            S_SCAN: begin
                op = OP_SCAN;
                if (i_stat.scan_found && r_ret != RET_COUNT) begin
                    case (r_ret)
                        RET_ALLOC: n_state = S_ALINK;
                        RET_WHEAD: n_state = S_WHEAD;
                        default:   n_state = S_WEXT;
                    endcase
                end else if (i_stat.scan_done) begin
                    n_state = S_DONE;
                    if (r_ret == RET_COUNT) begin
                        n_cnt_out = 1'b1;
                    end else begin
                        n_st   = ST_NO_FREE;
                        n_bsel = (r_ret == RET_ALLOC) ? BS_ZERO : BS_HEAD;
                    end
                end
            end
            S_ALINK: begin
                if (!i_stat.cur_is_end) begin
                    op = OP_LINK;
                end
                n_state = S_AMARK;
            end
            S_AMARK: begin
                op      = OP_MARK;
                n_bsel  = BS_FREE;
                n_state = S_DONE;
            end
            S_FREE: begin
                // Clear this entry and follow its old link
                op = OP_FREE;
                if (i_stat.rd_zero) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_FCHK;
                end
            end
            S_FCHK: begin
                if (i_stat.cur_is_end) begin
                    n_state = S_DONE;
                end else if (!i_stat.cur_in_range) begin
                    n_st    = ST_RANGE;
                    n_state = S_DONE;
                end else begin
                    n_state = S_FREE;
                end
            end
            S_WHEAD: begin
                op      = OP_HEAD_NEW;
                n_state = S_WCHK;
            end
            S_WCHK: begin
                if (i_stat.steps_zero) begin
                    n_bsel  = BS_CUR;
                    n_state = S_DONE;
                end else if (!i_stat.cur_in_range) begin
                    n_st    = ST_RANGE;
                    n_bsel  = BS_HEAD;
                    n_state = S_DONE;
                end else begin
                    n_state = S_WRD;
                end
            end
            S_WRD: begin
                if (!i_stat.rd_end) begin
                    op      = OP_ADV;
                    n_state = S_WCHK;
                end else if (!i_stat.extend) begin
                    n_st    = ST_PAST;
                    n_bsel  = BS_HEAD;
                    n_state = S_DONE;
                end else begin
                    op      = OP_SCAN_INIT;
                    n_ret   = RET_WEXT;
                    n_state = S_SCAN;
                end
            end
            S_WEXT: begin
                op      = OP_LINK;
                n_state = S_WEXT2;
            end
            S_WEXT2: begin
                op      = OP_MARK_ADV;
                n_state = S_WCHK;
            end
            S_DONE: begin
                op      = OP_DONE;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and registered command fields
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= RET_ALLOC;
            r_st      <= ST_OK;
            r_bsel    <= BS_ZERO;
            r_cnt_out <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_st      <= n_st;
            r_bsel    <= n_bsel;
            r_cnt_out <= n_cnt_out;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fat_chain_manager_top.sv =====
// ----------------------------------------------------------------------------
// fat_chain_manager_top
// Allocation table chain manager: load, read, allocate, free, walk, count.
//
//   Channel   Handshake                      Payload
//   command   start in, busy out             i_mode, i_block, i_entry_value,
//                                            i_steps, i_extend
//   result    o_done strobe, one cycle       o_block_out, o_disk_block,
//                                            o_head_allocated, o_free_count,
//                                            o_status
//   config    i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// Load and read pass through the dispatch and done states before the result
// strobe. A free-entry search or count reads one table entry per cycle through
// the single memory read port, from entry 1 to below data_block_count capped
// at the table depth; a free takes a clear and a check step per link followed,
// a walk a check and a read step plus, per extension, a search and two writes.
// Synchronous reset clears control and configuration; the table contents
// are undefined until loaded. The receiver cannot stall; busy drops as the
// result strobe rises.
// ----------------------------------------------------------------------------
`default_nettype none

module fat_chain_manager_top
    import fcm_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_mode,
    input  wire logic [15:0] i_block,
    input  wire logic [15:0] i_entry_value,
    input  wire logic [12:0] i_steps,
    input  wire logic        i_extend,
    output logic             o_done,
    output logic [15:0]      o_block_out,
    output logic [15:0]      o_disk_block,
    output logic             o_head_allocated,
    output logic [12:0]      o_free_count,
    output logic [1:0]       o_status,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    fcm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    fcm_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_mode           (i_mode),
        .i_block          (i_block),
        .i_entry_value    (i_entry_value),
        .i_steps          (i_steps),
        .i_extend         (i_extend),
        .i_cfg_we         (i_cfg_valid & o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_done           (o_done),
        .o_block_out      (o_block_out),
        .o_disk_block     (o_disk_block),
        .o_head_allocated (o_head_allocated),
        .o_free_count     (o_free_count),
        .o_status         (o_status)
    );

endmodule

`default_nettype wire
